/* src/qevc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, reset values and the quadrature transition table for the
// encoder volume control core. No dependencies.
package qevc_pkg;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic [1:0] REG_STEPS_PER_DETENT = 2'd0;
  localparam logic [1:0] REG_REVERSE_DIR      = 2'd1;
  localparam logic [1:0] REG_SETTLE_MS        = 2'd2;
  localparam logic [1:0] REG_VOLUME_MAX       = 2'd3;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [3:0] STEPS_RESET   = 4'd4;
  localparam logic       REVERSE_RESET = 1'b1;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd30;
  localparam logic [6:0] VOLMAX_RESET  = 7'd100;
  localparam logic [6:0] VOLUME_RESET  = 7'd50;
  localparam logic [1:0] PHASES_RESET  = 2'b11;

  typedef logic signed [4:0] move_acc_t;
  typedef logic signed [1:0] dir_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        switch_level;
    logic        phase_b;
    logic        phase_a;
  } sample_t;

  // Movement contributed by the transition from prev to cur phase pair.
  function automatic dir_t step_of(input logic [1:0] prev, input logic [1:0] cur);
    dir_t d;
    d = 2'sd0;
    case ({prev, cur})
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

/* src/quadrature_encoder_volume_control_core.sv */
`timescale 1ns / 1ps
// Quadrature encoder decoder with detent counting, saturating volume and a
// debounced pause toggle. Depends on qevc_pkg.
//
// Usage:
//   Input stream s_*: one request per sample of the two encoder phases, the
//   push switch level and a millisecond timestamp. Output stream m_*: one
//   result per sample with the volume, pause flag, detent direction and a
//   pause-toggle strobe.
//   The APB port holds four registers at byte addresses 0, 4, 8 and 12:
//   steps per detent, reverse direction, debounce time in ms and volume max.
//   Write them only while no sample is in flight.
//   An accepted sample is held in the input register; the update of all state
//   and the result register, which drives m_tvalid, follow when the result
//   register is empty or m_tready is high. Throughput is one sample per cycle
//   while m_tready stays high, set by the combinational state update between.
//   A waiting result does not block input: the input register still takes
//   one sample, and s_tready falls only when both registers are full and
//   m_tready is low.
//   Reset puts both phases and the switch at high (released), the volume at
//   50, pause off, and the registers at 4, 1, 30 and 100.
module quadrature_encoder_volume_control_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // phase_a[0], phase_b[1], switch_level[2], now_ms[34:3], zero fill [39:35]
  input  logic [qevc_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // volume[6:0], paused[7], detent_dir[9:8], pause_toggled[10], zero fill [15:11]
  output logic [qevc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qevc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [qevc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [qevc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import qevc_pkg::*;

  // Configuration registers.
  logic [3:0] steps_per_detent;
  logic       dir_invert;
  logic [7:0] settle_ms;
  logic [6:0] volume_max;

  logic       cfg_write;
  logic [1:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_detent <= STEPS_RESET;
      dir_invert       <= REVERSE_RESET;
      settle_ms        <= DEBOUNCE_RESET;
      volume_max       <= VOLMAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEPS_PER_DETENT: steps_per_detent <= pwdata[3:0];
        REG_REVERSE_DIR:      dir_invert       <= pwdata[0];
        REG_SETTLE_MS:        settle_ms        <= pwdata[7:0];
        REG_VOLUME_MAX:       volume_max       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_index)
      REG_STEPS_PER_DETENT: prdata[3:0] = steps_per_detent;
      REG_REVERSE_DIR:      prdata[0]   = dir_invert;
      REG_SETTLE_MS:        prdata[7:0] = settle_ms;
      REG_VOLUME_MAX:       prdata[6:0] = volume_max;
      default:              prdata      = '0;
    endcase
  end

  // Input register and result register handshake.
  logic    in_valid;
  sample_t in_sample;
  logic    advance;
  logic    out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= sample_t'(s_tdata[34:0]);
    end
  end

  // Decoder state.
  logic [1:0]  prev_phases;
  move_acc_t   movement_acc;
  logic [6:0]  volume_level;
  logic        pause_flag;
  logic        last_switch_raw;
  logic        stable_switch;
  logic [31:0] switch_changed_time;

  logic [1:0]  prev_phases_next;
  move_acc_t   movement_acc_next;
  logic [6:0]  volume_level_next;
  logic        pause_flag_next;
  logic        last_switch_raw_next;
  logic        stable_switch_next;
  logic [31:0] switch_changed_time_next;
  dir_t        dir_next;
  logic        toggled_next;

  logic [1:0]  cur_phases;
  move_acc_t   acc_sum;
  move_acc_t   thr;
  logic signed [8:0] vol_sum;
  logic [31:0] elapsed;

  always_comb begin
    cur_phases       = {in_sample.phase_a, in_sample.phase_b};
    thr              = (steps_per_detent == 4'd0) ? 5'sd1 : $signed({1'b0, steps_per_detent});
    prev_phases_next = prev_phases;
    movement_acc_next = movement_acc;
    volume_level_next = volume_level;
    dir_next         = 2'sd0;
    acc_sum          = movement_acc;
    vol_sum          = $signed({2'b0, volume_level});

    if (cur_phases != prev_phases) begin
      prev_phases_next = cur_phases;
      // A jump over both phases is a missed sample, so the partial count is dropped.
      if ((cur_phases ^ prev_phases) == 2'b11) begin
        acc_sum = 5'sd0;
      end else begin
        acc_sum = movement_acc + 5'(step_of(prev_phases, cur_phases));
      end
      movement_acc_next = acc_sum;
      if (acc_sum >= thr || acc_sum <= -thr) begin
        movement_acc_next = 5'sd0;
        dir_next = ((acc_sum > 5'sd0) != dir_invert) ? 2'sd1 : -2'sd1;
        vol_sum  = $signed({2'b0, volume_level}) + 9'(dir_next);
        if (vol_sum < 9'sd0) begin
          volume_level_next = 7'd0;
        end else if (vol_sum > $signed({2'b0, volume_max})) begin
          volume_level_next = volume_max;
        end else begin
          volume_level_next = vol_sum[6:0];
        end
      end
    end

    last_switch_raw_next     = in_sample.switch_level;
    switch_changed_time_next = switch_changed_time;
    if (in_sample.switch_level != last_switch_raw) begin
      switch_changed_time_next = in_sample.now_ms;
    end
    elapsed            = in_sample.now_ms - switch_changed_time_next;
    stable_switch_next = stable_switch;
    pause_flag_next    = pause_flag;
    toggled_next       = 1'b0;
    if (elapsed >= {24'd0, settle_ms} && in_sample.switch_level != stable_switch) begin
      stable_switch_next = in_sample.switch_level;
      if (!in_sample.switch_level) begin
        pause_flag_next = !pause_flag;
        toggled_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phases         <= PHASES_RESET;
      movement_acc        <= 5'sd0;
      volume_level        <= VOLUME_RESET;
      pause_flag          <= 1'b0;
      last_switch_raw     <= 1'b1;
      stable_switch       <= 1'b1;
      switch_changed_time <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (advance) begin
        prev_phases         <= prev_phases_next;
        movement_acc        <= movement_acc_next;
        volume_level        <= volume_level_next;
        pause_flag          <= pause_flag_next;
        last_switch_raw     <= last_switch_raw_next;
        stable_switch       <= stable_switch_next;
        switch_changed_time <= switch_changed_time_next;
        out_valid           <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {5'd0, toggled_next, dir_next, pause_flag_next, volume_level_next};
    end
  end

  // The result register never carries the unused direction code.
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:8] != 2'b10))
    else $error("detent direction holds an invalid code");

  // A reported toggle must have flipped the stored pause flag.
  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    (advance && toggled_next) |=> (pause_flag != $past(pause_flag)))
    else $error("pause toggle without a flag change");

  // A counted detent leaves the volume within the limit.
  a_detent_limit: assert property (@(posedge clk) disable iff (rst)
    (advance && dir_next != 2'sd0) |=> (volume_level <= volume_max))
    else $error("volume above limit after a detent");

  // With the result register empty the block always takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with an empty result register");

endmodule
